FILE: rtl/core/c8_pkg.sv
// ----------------------------------------------------------------------------
// c8_pkg
// shared types and constants of the chip-8 instruction core
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int ADDR_W = 12;
  localparam logic [11:0] PC_RESET  = 12'h200;
  localparam logic [15:0] FONT_BASE = 16'h0050;

  // low nibble of an 8xyn opcode
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  typedef struct packed {
    logic [7:0] value;
    logic       flag;
    logic       flag_we;
    logic       known;
  } alu_res_t;

endpackage

FILE: rtl/core/c8_ram.sv
// ----------------------------------------------------------------------------
// c8_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/c8_alu.sv
// ----------------------------------------------------------------------------
// c8_alu
// register-to-register arithmetic of the 8xyn opcode group
// ----------------------------------------------------------------------------
module c8_alu (
  input  logic              [7:0] vx,
  input  logic              [7:0] vy,
  input  logic              [3:0] fn,
  input  logic                    legacy,
  output c8_pkg::alu_res_t        res
);
  import c8_pkg::*;

  logic [8:0] sum;
  logic [7:0] src;

  always_comb begin
    sum = {1'b0, vx} + {1'b0, vy};
    // legacy shifts take vy as the source
    src = legacy ? vy : vx;
    res = '{value: vx, flag: 1'b0, flag_we: 1'b0, known: 1'b1};
    unique case (fn)
      ALU_MOV: res.value = vy;
      ALU_OR:  res.value = vx | vy;
      ALU_AND: res.value = vx & vy;
      ALU_XOR: res.value = vx ^ vy;
      ALU_ADD: res = '{value: sum[7:0], flag: sum[8], flag_we: 1'b1, known: 1'b1};
      ALU_SUB: res = '{value: vx - vy, flag: (vx >= vy), flag_we: 1'b1, known: 1'b1};
      ALU_SBN: res = '{value: vy - vx, flag: (vy >= vx), flag_we: 1'b1, known: 1'b1};
      ALU_SHR: res = '{value: {1'b0, src[7:1]}, flag: src[0], flag_we: 1'b1, known: 1'b1};
      ALU_SHL: res = '{value: {src[6:0], 1'b0}, flag: src[7], flag_we: 1'b1, known: 1'b1};
      default: res.known = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip-8 core: execute, timer tick, memory write and screen row read commands
// ----------------------------------------------------------------------------
//   channel  | signals                         | accepted when
//   ---------+---------------------------------+--------------------------
//   input    | in_valid, in_stall, cmd..row    | in_valid && !in_stall
//   output   | out_valid, out_stall, pc..row   | out_valid && !out_stall
//   config   | cfg_we, cfg_index, cfg_data     | cfg_we
//
// tick and memory write go to S_DONE, row read via S_ROW, an instruction via
// S_F1, S_F2, S_RV1, S_RV2, S_EX (two byte fetches and two register reads),
// plus S_WF for a flag write or S_RET for a return. draw adds S_D0, S_D1 per
// drawn sprite row plus S_WF for the flag, block store/load S_M0, S_M1 per
// register, bcd S_B1, S_B2. after reset a clearing pass zeroes main memory
// with in_stall high; config writes are taken meanwhile. a new command is
// taken while the previous result still waits in the output register.
module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] keys_held,
  input  logic        key_released_valid,
  input  logic [3:0]  key_released_value,
  input  logic [7:0]  random_byte,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_data,
  input  logic [4:0]  row_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] program_counter,
  output logic [1:0]  status,
  output logic        sound_on,
  output logic        screen_changed,
  output logic [63:0] row_pixels,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [0:0]  cfg_data
);
  import c8_pkg::*;

  localparam int SC_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_ROW   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNK   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam logic [1:0] CFG_LEGACY = 2'd0;
  localparam logic [1:0] CFG_IFLAG  = 2'd1;
  localparam logic [1:0] CFG_KEEP   = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ROW, S_F1, S_F2, S_RV1, S_RV2, S_EX, S_WF, S_RET,
    S_D0, S_D1, S_B1, S_B2, S_M0, S_M1, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic legacy, iflag_en, keep_idx;

  // architectural state outside the rams
  logic [15:0]     idx;
  logic [11:0]     pc;
  logic [SC_W-1:0] sc;
  logic [7:0]      delay_cnt, sound_cnt;
  logic [15:0]     v_valid;
  logic [31:0]     f_valid, row_nz;

  // per-transaction working registers
  logic [15:0] keys_q;
  logic        krv_q;
  logic [3:0]  krval_q;
  logic [7:0]  rand_q;
  logic [4:0]  rsel_q;
  logic [7:0]  op_hi, op_lo, vx, vy;
  logic [1:0]  stat_q;
  logic        chg_q, flag_q, hit_q, is55;
  logic [63:0] row_q;
  logic [3:0]  cnt;
  logic [4:0]  drow;
  logic [11:0] clr_cnt;
  logic [3:0]  v_ra_q;

  // ram ports
  logic        m_we;
  logic [11:0] m_wa, m_ra;
  logic [7:0]  m_wd, m_rd;
  logic        v_we;
  logic [3:0]  v_wa, v_ra;
  logic [7:0]  v_wd, v_rd, vq;
  logic        s_we;
  logic [SI_W-1:0] s_wa, s_ra;
  logic [11:0] s_wd, s_rd;
  logic        f_we;
  logic [4:0]  f_wa, f_ra;
  logic [63:0] f_wd, f_rd;

  logic            accept;
  logic [3:0]      hi, x, n;
  logic [11:0]     nnn, pcn;
  logic [SC_W-1:0] sc_dec;
  logic [16:0]     isum;
  logic [63:0]     d_old, d_mask, d_new;
  logic [7:0]      b_h, b_t, b_o;
  alu_res_t        alu;

  function automatic logic [23:0] bcd(input logic [7:0] val);
    logic [7:0] h, t, r;
    h = (val >= 8'd200) ? 8'd2 : ((val >= 8'd100) ? 8'd1 : 8'd0);
    r = val - 8'(h * 8'd100);
    t = 8'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) t = 8'(k);
    end
    return {h, t, 8'(r - 8'(t * 8'd10))};
  endfunction

  assign hi     = op_hi[7:4];
  assign x      = op_hi[3:0];
  assign n      = op_lo[3:0];
  assign nnn    = {op_hi[3:0], op_lo};
  assign pcn    = pc + 12'd2;
  assign sc_dec = sc - SC_W'(1);
  assign isum   = {1'b0, idx} + {9'b0, vx};
  assign vq     = v_valid[v_ra_q] ? v_rd : 8'h00;
  assign d_old  = f_valid[drow] ? f_rd : 64'h0;
  assign d_mask = {m_rd, 56'h0} >> vx[5:0];
  assign d_new  = d_old ^ d_mask;
  assign {b_h, b_t, b_o} = bcd(vx);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  c8_alu u_alu (.vx(vx), .vy(vy), .fn(n), .legacy(legacy), .res(alu));

  c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  c8_ram #(.WIDTH(64), .DEPTH(32)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  // ram port steering
  always_comb begin
    m_we = 1'b0; m_wa = idx[11:0]; m_wd = 8'h00;
    m_ra = pc;
    v_we = 1'b0; v_wa = x; v_wd = 8'h00;
    v_ra = x;
    s_we = 1'b0; s_wa = sc[SI_W-1:0]; s_wd = pcn;
    s_ra = sc_dec[SI_W-1:0];
    f_we = 1'b0; f_wa = drow; f_wd = d_new;
    f_ra = (state == S_D0) ? drow : row_select;
    unique case (state)
      S_CLEAR: begin
        m_we = 1'b1; m_wa = clr_cnt;
      end
      S_IDLE: begin
        if (accept && cmd == CMD_WRITE) begin
          m_we = 1'b1; m_wa = load_address; m_wd = load_data;
        end
      end
      S_F1: m_ra = pc + 12'd1;
      S_F2: v_ra = op_hi[3:0];
      S_RV1: v_ra = (hi == 4'hB && legacy) ? 4'h0 : op_lo[7:4];
      S_EX: begin
        unique case (hi)
          4'h2: s_we = (sc < SC_W'(STACK_DEPTH));
          4'h6: begin v_we = 1'b1; v_wd = op_lo; end
          4'h7: begin v_we = 1'b1; v_wd = vx + op_lo; end
          4'h8: begin v_we = alu.known; v_wd = alu.value; end
          4'hC: begin v_we = 1'b1; v_wd = op_lo & rand_q; end
          4'hF: begin
            if (op_lo == 8'h07) begin
              v_we = 1'b1; v_wd = delay_cnt;
            end else if (op_lo == 8'h0A && krv_q) begin
              v_we = 1'b1; v_wd = {4'h0, krval_q};
            end else if (op_lo == 8'h33) begin
              m_we = 1'b1; m_wd = b_h;
            end
          end
          default: ;
        endcase
      end
      S_WF: begin
        v_we = 1'b1; v_wa = 4'hF; v_wd = {7'h0, flag_q};
      end
      S_D0: m_ra = idx[11:0] + {8'h0, cnt};
      S_D1: f_we = 1'b1;
      S_B1: begin m_we = 1'b1; m_wa = idx[11:0] + 12'd1; m_wd = b_t; end
      S_B2: begin m_we = 1'b1; m_wa = idx[11:0] + 12'd2; m_wd = b_o; end
      S_M0: begin
        v_ra = cnt;
        m_ra = idx[11:0] + {8'h0, cnt};
      end
      S_M1: begin
        if (is55) begin
          m_we = 1'b1; m_wa = idx[11:0] + {8'h0, cnt}; m_wd = vq;
        end else begin
          v_we = 1'b1; v_wa = cnt; v_wd = m_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      legacy    <= 1'b0;
      iflag_en  <= 1'b0;
      keep_idx  <= 1'b1;
      idx       <= '0;
      pc        <= PC_RESET;
      sc        <= '0;
      delay_cnt <= '0;
      sound_cnt <= '0;
      v_valid   <= '0;
      f_valid   <= '0;
      row_nz    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEGACY: legacy   <= cfg_data[0];
          CFG_IFLAG:  iflag_en <= cfg_data[0];
          CFG_KEEP:   keep_idx <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (v_we) v_valid[v_wa] <= 1'b1;
      v_ra_q <= v_ra;

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 12'd1;
          if (clr_cnt == 12'hFFF) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            keys_q  <= keys_held;
            krv_q   <= key_released_valid;
            krval_q <= key_released_value;
            rand_q  <= random_byte;
            rsel_q  <= row_select;
            stat_q  <= ST_OK;
            chg_q   <= 1'b0;
            row_q   <= '0;
            unique case (cmd)
              CMD_EXEC: state <= S_F1;
              CMD_TICK: begin
                if (delay_cnt != 8'h00) delay_cnt <= delay_cnt - 8'd1;
                if (sound_cnt != 8'h00) sound_cnt <= sound_cnt - 8'd1;
                state <= S_DONE;
              end
              CMD_WRITE: state <= S_DONE;
              CMD_ROW:   state <= S_ROW;
              default: ;
            endcase
          end
        end
        S_ROW: begin
          row_q <= f_valid[rsel_q] ? f_rd : 64'h0;
          state <= S_DONE;
        end
        S_F1: begin op_hi <= m_rd; state <= S_F2; end
        S_F2: begin op_lo <= m_rd; state <= S_RV1; end
        S_RV1: begin vx <= vq; state <= S_RV2; end
        S_RV2: begin vy <= vq; state <= S_EX; end
        S_EX: begin
          pc    <= pcn;
          state <= S_DONE;
          unique case (hi)
            4'h0: begin
              if (nnn == 12'h0E0) begin
                chg_q   <= |row_nz;
                f_valid <= '0;
                row_nz  <= '0;
              end else if (nnn == 12'h0EE) begin
                if (sc == '0) begin
                  stat_q <= ST_UNDER;
                end else begin
                  sc    <= sc_dec;
                  state <= S_RET;
                end
              end else begin
                stat_q <= ST_UNK;
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sc >= SC_W'(STACK_DEPTH)) begin
                stat_q <= ST_OVER;
              end else begin
                sc <= sc + SC_W'(1);
                pc <= nnn;
              end
            end
            4'h3: if (vx == op_lo) pc <= pc + 12'd4;
            4'h4: if (vx != op_lo) pc <= pc + 12'd4;
            4'h5: if (vx == vy) pc <= pc + 12'd4;
            4'h9: if (vx != vy) pc <= pc + 12'd4;
            4'h6, 4'h7, 4'hC: ;
            4'h8: begin
              if (!alu.known) begin
                stat_q <= ST_UNK;
              end else if (alu.flag_we) begin
                flag_q <= alu.flag;
                state  <= S_WF;
              end
            end
            4'hA: idx <= {4'h0, nnn};
            4'hB: pc <= nnn + {4'h0, (legacy ? vy : vx)};
            4'hD: begin
              cnt   <= '0;
              drow  <= vy[4:0];
              hit_q <= 1'b0;
              if (n == 4'h0) begin
                flag_q <= 1'b0;
                state  <= S_WF;
              end else begin
                state <= S_D0;
              end
            end
            4'hE: begin
              if (op_lo == 8'h9E) begin
                if (keys_q[vx[3:0]]) pc <= pc + 12'd4;
              end else if (op_lo == 8'hA1) begin
                if (!keys_q[vx[3:0]]) pc <= pc + 12'd4;
              end else begin
                stat_q <= ST_UNK;
              end
            end
            4'hF: begin
              priority case (op_lo)
                8'h07: ;
                8'h15: delay_cnt <= vx;
                8'h18: sound_cnt <= vx;
                8'h1E: begin
                  idx <= isum[15:0];
                  if (iflag_en) begin
                    flag_q <= (isum >= 17'h01000);
                    state  <= S_WF;
                  end
                end
                8'h0A: if (!krv_q) pc <= pc;
                8'h29: idx <= FONT_BASE + ({8'h0, vx} * 16'd5);
                8'h33: state <= S_B1;
                8'h55, 8'h65: begin
                  cnt   <= '0;
                  is55  <= (op_lo == 8'h55);
                  state <= S_M0;
                end
                default: stat_q <= ST_UNK;
              endcase
            end
            default: ;
          endcase
        end
        S_WF: state <= S_DONE;
        S_RET: begin pc <= s_rd; state <= S_DONE; end
        S_D0: state <= S_D1;
        S_D1: begin
          f_valid[drow] <= 1'b1;
          row_nz[drow]  <= |d_new;
          if (|d_mask) chg_q <= 1'b1;
          if (|(d_old & d_mask)) hit_q <= 1'b1;
          if ((cnt + 4'd1) < n && drow != 5'd31) begin
            cnt   <= cnt + 4'd1;
            drow  <= drow + 5'd1;
            state <= S_D0;
          end else begin
            flag_q <= hit_q | (|(d_old & d_mask));
            state  <= S_WF;
          end
        end
        S_B1: state <= S_B2;
        S_B2: state <= S_DONE;
        S_M0: state <= S_M1;
        S_M1: begin
          if (cnt == x) begin
            if (!keep_idx) idx <= idx + {12'h0, x} + 16'd1;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_M0;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            program_counter <= pc;
            status          <= stat_q;
            sound_on        <= (sound_cnt != 8'h00);
            screen_changed  <= chg_q;
            row_pixels      <= row_q;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
